// ----- src/mhpq_pkg.sv -----
// mhpq_pkg: shared types and constants of the min-heap priority queue
// no dependencies; used by mhpq_store and min_heap_priority_queue
package mhpq_pkg;

   localparam int CAPACITY  = 64;
   localparam int KEY_WIDTH = 32;
   localparam int ADDR_W    = $clog2(CAPACITY);
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int CHILD_W   = ADDR_W + 2;

   typedef logic signed [KEY_WIDTH-1:0] key_type;
   typedef logic [ADDR_W-1:0]           addr_type;
   typedef logic [CNT_W-1:0]            cnt_type;
   typedef logic [CHILD_W-1:0]          child_type;

   typedef logic       func_type;
   typedef logic [1:0] err_type;

   localparam func_type FUNC_PUSH = 1'b0;
   localparam func_type FUNC_POP  = 1'b1;

   localparam err_type ERR_NONE      = 2'd0;
   localparam err_type ERR_POP_EMPTY = 2'd1;
   localparam err_type ERR_PUSH_FULL = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LAST_RD,
      S_LAST_LD,
      S_UP_RD,
      S_UP_CMP,
      S_DN_RD,
      S_DN_CMP
   } state_type;

   typedef struct packed {
      logic     wr_en;
      addr_type wr_addr;
      key_type  wr_data;
      addr_type rd_addr_a;
      addr_type rd_addr_b;
   } store_req_type;

   typedef struct packed {
      key_type rd_data_a;
      key_type rd_data_b;
      key_type root_next;
   } store_rsp_type;

endpackage

// ----- src/mhpq_ram.sv -----
// mhpq_ram: generic single-write, single-read ram with registered read data
// no dependencies
module mhpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/mhpq_store.sv -----
// mhpq_store: heap array as two mirrored ram copies for two reads a cycle,
// plus a register that mirrors the root entry; uses mhpq_pkg and mhpq_ram
module mhpq_store
   import mhpq_pkg::*;
(
   input  logic          clock,
   input  store_req_type req,
   output store_rsp_type rsp
);

   key_type root_ff;
   key_type root_in;
   key_type rd_a;
   key_type rd_b;

   mhpq_ram #(.WIDTH(KEY_WIDTH), .DEPTH(CAPACITY)) u_ram_a (
      .clock   (clock),
      .wr_en   (req.wr_en),
      .wr_addr (req.wr_addr),
      .wr_data (req.wr_data),
      .rd_addr (req.rd_addr_a),
      .rd_data (rd_a)
   );

   mhpq_ram #(.WIDTH(KEY_WIDTH), .DEPTH(CAPACITY)) u_ram_b (
      .clock   (clock),
      .wr_en   (req.wr_en),
      .wr_addr (req.wr_addr),
      .wr_data (req.wr_data),
      .rd_addr (req.rd_addr_b),
      .rd_data (rd_b)
   );

   always_comb begin
      root_in = root_ff;
      if (req.wr_en && req.wr_addr == '0) begin
         root_in = req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      root_ff <= root_in;
   end

   assign rsp.rd_data_a = rd_a;
   assign rsp.rd_data_b = rd_b;
   assign rsp.root_next = root_in;

endmodule

// ----- src/min_heap_priority_queue.sv -----
// min_heap_priority_queue: top level, command sequencer for push and pop
// uses mhpq_pkg and mhpq_store (which holds the heap in ram)
//
// An item is taken when start is high and busy is low. A push walks the new
// key up the heap and a pop walks the former last entry down from the root,
// one level per read-compare-write turn of the heap ram. Errors and a pop
// that empties the queue finish at once and never raise busy. The result is
// shown for exactly one cycle with rsp_strobe, in the cycle busy falls, and
// cannot be held off, so it must be captured then. A new item may be started
// in that same cycle.
module min_heap_priority_queue
   import mhpq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_func,
   input  logic signed [KEY_WIDTH-1:0] req_key,
   output logic                  rsp_strobe,
   output logic signed [KEY_WIDTH-1:0] rsp_min_key,
   output logic                  rsp_is_empty,
   output logic [CNT_W-1:0]      rsp_entry_count,
   output logic [1:0]            rsp_error_code
);

   state_type     state_ff, state_in;
   cnt_type       count_ff, count_in;
   addr_type      pos_ff, pos_in;
   key_type       cur_ff, cur_in;

   logic          rsp_strobe_ff, rsp_strobe_in;
   key_type       rsp_min_key_ff, rsp_min_key_in;
   logic          rsp_is_empty_ff, rsp_is_empty_in;
   cnt_type       rsp_entry_count_ff, rsp_entry_count_in;
   err_type       rsp_error_code_ff, rsp_error_code_in;

   store_req_type store_req;
   store_rsp_type store_rsp;

   logic          finish;
   err_type       err;
   addr_type      parent;
   child_type     left, right, child_idx;
   logic          left_ok, right_ok, pick_r;
   key_type       child;

   mhpq_store u_store (
      .clock (clock),
      .req   (store_req),
      .rsp   (store_rsp)
   );

   // parent and child indices, and child selection, for the walks up and down
   always_comb begin
      parent    = addr_type'((pos_ff - addr_type'(1)) >> 1);
      left      = child_type'({pos_ff, 1'b1});
      right     = left + child_type'(1);
      left_ok   = left < child_type'(count_ff);
      right_ok  = right < child_type'(count_ff);
      pick_r    = right_ok && (store_rsp.rd_data_b < store_rsp.rd_data_a);
      child     = pick_r ? store_rsp.rd_data_b : store_rsp.rd_data_a;
      child_idx = pick_r ? right : left;
   end

   always_comb begin
      state_in            = state_ff;
      count_in            = count_ff;
      pos_in              = pos_ff;
      cur_in              = cur_ff;
      finish              = 1'b0;
      err                 = ERR_NONE;
      store_req.wr_en     = 1'b0;
      store_req.wr_addr   = pos_ff;
      store_req.wr_data   = cur_ff;
      store_req.rd_addr_a = parent;
      store_req.rd_addr_b = right[ADDR_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_func == FUNC_PUSH) begin
                  if (count_ff == cnt_type'(CAPACITY)) begin
                     finish = 1'b1;
                     err    = ERR_PUSH_FULL;
                  end else begin
                     cur_in   = req_key;
                     pos_in   = count_ff[ADDR_W-1:0];
                     count_in = count_ff + cnt_type'(1);
                     state_in = S_UP_RD;
                  end
               end else begin
                  if (count_ff == '0) begin
                     finish = 1'b1;
                     err    = ERR_POP_EMPTY;
                  end else begin
                     count_in = count_ff - cnt_type'(1);
                     if (count_ff == cnt_type'(1)) begin
                        finish = 1'b1;
                     end else begin
                        state_in = S_LAST_RD;
                     end
                  end
               end
            end
         end
         S_LAST_RD: begin
            store_req.rd_addr_a = count_ff[ADDR_W-1:0];
            state_in            = S_LAST_LD;
         end
         S_LAST_LD: begin
            cur_in   = store_rsp.rd_data_a;
            pos_in   = '0;
            state_in = S_DN_RD;
         end
         S_UP_RD: begin
            if (pos_ff == '0) begin
               store_req.wr_en = 1'b1;
               finish          = 1'b1;
               state_in        = S_IDLE;
            end else begin
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            store_req.wr_en = 1'b1;
            if (cur_ff < store_rsp.rd_data_a) begin
               store_req.wr_data = store_rsp.rd_data_a;
               pos_in            = parent;
               state_in          = S_UP_RD;
            end else begin
               finish   = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_DN_RD: begin
            store_req.rd_addr_a = left[ADDR_W-1:0];
            if (!left_ok) begin
               store_req.wr_en = 1'b1;
               finish          = 1'b1;
               state_in        = S_IDLE;
            end else begin
               state_in = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            store_req.wr_en = 1'b1;
            if (child < cur_ff) begin
               store_req.wr_data = child;
               pos_in            = child_idx[ADDR_W-1:0];
               state_in          = S_DN_RD;
            end else begin
               finish   = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_strobe_in      = finish;
      rsp_error_code_in  = err;
      rsp_entry_count_in = count_in;
      rsp_is_empty_in    = (count_in == '0);
      rsp_min_key_in     = (count_in == '0) ? key_type'(0) : store_rsp.root_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff             <= pos_in;
      cur_ff             <= cur_in;
      rsp_min_key_ff     <= rsp_min_key_in;
      rsp_is_empty_ff    <= rsp_is_empty_in;
      rsp_entry_count_ff <= rsp_entry_count_in;
      rsp_error_code_ff  <= rsp_error_code_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_min_key     = rsp_min_key_ff;
   assign rsp_is_empty    = rsp_is_empty_ff;
   assign rsp_entry_count = rsp_entry_count_ff;
   assign rsp_error_code  = rsp_error_code_ff;

endmodule
